FILE: rtl/core/bpfa_pkg.sv
package bpfa_pkg;

    localparam int DEF_MAX_PAGES    = 4096;
    localparam int DEF_PAGE_BYTES   = 4096;
    localparam int ADDRESS_BITS     = 48;

    localparam int ADDR_W   = 48;
    localparam int ACT_W    = 3;
    localparam int STATUS_W = 3;
    localparam int COUNT_W  = 13;
    localparam int CFG_IDX_W = 1;
    localparam int WORD_BITS = 64;
    localparam int BIT_W     = 6;

    localparam logic [COUNT_W-1:0] COUNT_MAX    = '1;
    localparam logic [COUNT_W-1:0] TOTAL_RESET  = 13'd4096;

    localparam logic [ADDR_W-1:0] GRANT_MASK =
        (ADDRESS_BITS >= ADDR_W) ? {ADDR_W{1'b1}}
                                 : ADDR_W'((64'd1 << ADDRESS_BITS) - 64'd1);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BASE_ADDRESS = 1'b0,
        REG_TOTAL_PAGES  = 1'b1
    } cfg_reg_t;

    typedef enum logic [ACT_W-1:0] {
        ACT_REQUEST = 3'd0,
        ACT_LOCK    = 3'd1,
        ACT_FREE    = 3'd2,
        ACT_RESERVE = 3'd3,
        ACT_RELEASE = 3'd4
    } action_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_EXHAUSTED = 3'd1,
        ST_BUSY      = 3'd2,
        ST_FREE      = 3'd3,
        ST_BAD       = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_SCAN,
        S_MODIFY,
        S_OUT
    } state_t;

endpackage

FILE: rtl/core/bitmap_page_frame_allocator.sv
// Channel   Direction  Handshake            Beat contents
// s_        in         s_valid / s_ready    s_action, s_page_address
// m_        out        m_valid / m_ready    m_granted_address, m_status, m_*_pages
// cfg_      in         cfg_wr_en            cfg_index, cfg_wdata
//
// Lock, free, reserve and release beats go through decode, modify and output before
// the next accept; rejected beats and unknown actions go from decode to output.
// A request decodes, then scans words up to the one with the last configured page,
// one 64-bit word per cycle through the single bitmap RAM read port, then outputs.
// After reset a clearing pass zeroes the bitmap, one word per cycle.
// A result waiting in the output register does not stop the next beat being accepted.
module bitmap_page_frame_allocator #(
    parameter int MAX_PAGES  = bpfa_pkg::DEF_MAX_PAGES,
    parameter int PAGE_BYTES = bpfa_pkg::DEF_PAGE_BYTES
) (
    input  logic                              aclk,
    input  logic                              aresetn,

    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [bpfa_pkg::ACT_W-1:0]        s_action,
    input  logic [bpfa_pkg::ADDR_W-1:0]       s_page_address,

    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [bpfa_pkg::ADDR_W-1:0]       m_granted_address,
    output logic [bpfa_pkg::STATUS_W-1:0]     m_status,
    output logic [bpfa_pkg::COUNT_W-1:0]      m_free_pages,
    output logic [bpfa_pkg::COUNT_W-1:0]      m_used_pages,
    output logic [bpfa_pkg::COUNT_W-1:0]      m_reserved_pages,

    input  logic                              cfg_wr_en,
    input  logic [bpfa_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [bpfa_pkg::ADDR_W-1:0]       cfg_wdata
);

    import bpfa_pkg::*;

    localparam int WORDS      = (MAX_PAGES + WORD_BITS - 1) / WORD_BITS;
    localparam int WORD_AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int IDX_W      = $clog2(MAX_PAGES);
    localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
    localparam logic [COUNT_W-1:0] MAX_CAP =
        (MAX_PAGES < 8192) ? COUNT_W'(MAX_PAGES) : {COUNT_W{1'b1}};
    localparam logic [WORD_AW-1:0] LAST_WORD = WORD_AW'(WORDS - 1);

    state_t                 state_reg, state_next;
    logic [ACT_W-1:0]       act_reg, act_next;
    logic [ADDR_W-1:0]      addr_reg, addr_next;
    logic [IDX_W-1:0]       idx_reg, idx_next;
    logic [WORD_AW-1:0]     scan_word_reg, scan_word_next;
    logic [WORD_AW-1:0]     clr_addr_reg, clr_addr_next;
    logic [COUNT_W-1:0]     used_reg, used_next;
    logic [COUNT_W-1:0]     rsvd_reg, rsvd_next;
    logic [ADDR_W-1:0]      base_reg, base_next;
    logic [COUNT_W-1:0]     total_reg, total_next;
    logic [ADDR_W-1:0]      res_granted_reg, res_granted_next;
    status_t                res_status_reg, res_status_next;
    logic                   m_valid_reg, m_valid_next;
    logic [ADDR_W-1:0]      m_granted_reg, m_granted_next;
    logic [STATUS_W-1:0]    m_status_reg, m_status_next;
    logic [COUNT_W-1:0]     m_free_reg, m_free_next;
    logic [COUNT_W-1:0]     m_used_reg, m_used_next;
    logic [COUNT_W-1:0]     m_rsvd_reg, m_rsvd_next;

    logic                   ram_we;
    logic [WORD_AW-1:0]     ram_waddr;
    logic [WORD_BITS-1:0]   ram_wdata;
    logic [WORD_AW-1:0]     ram_raddr;
    logic [WORD_BITS-1:0]   ram_rdata;

    logic [COUNT_W-1:0]     eff_total;
    logic [COUNT_W-1:0]     eff_m1;
    logic [WORD_AW-1:0]     last_word;
    logic [BIT_W-1:0]       rem_bits;
    logic [WORD_BITS-1:0]   tail_mask;
    logic [WORD_BITS-1:0]   avail;
    logic                   found;
    logic [BIT_W-1:0]       found_pos;
    logic                   base_misaligned;
    logic [ADDR_W-1:0]      diff;
    logic [ADDR_W-1:0]      quot;
    logic                   addr_bad;
    logic [WORD_AW+BIT_W-1:0] gidx;
    logic [63:0]            grant_sum;
    logic [BIT_W-1:0]       bit_pos;
    logic                   bit_val;
    logic [COUNT_W:0]       taken;

    bpfa_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (WORDS)
    ) u_bitmap (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // effective total, scan bounds, address decode
    always_comb begin
        eff_total = (total_reg > MAX_CAP) ? MAX_CAP : total_reg;
        eff_m1    = eff_total - COUNT_W'(1);
        last_word = WORD_AW'(eff_m1 >> BIT_W);
        rem_bits  = eff_total[BIT_W-1:0];
        tail_mask = (rem_bits == '0) ? {WORD_BITS{1'b1}}
                                     : ((WORD_BITS'(1) << rem_bits) - WORD_BITS'(1));
        avail = ~ram_rdata & ((scan_word_reg == last_word) ? tail_mask : {WORD_BITS{1'b1}});
        found = |avail;
        found_pos = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (avail[i]) begin
                found_pos = BIT_W'(i);
            end
        end
        base_misaligned = |base_reg[PAGE_SHIFT-1:0];
        diff     = addr_reg - base_reg;
        quot     = diff >> PAGE_SHIFT;
        addr_bad = base_misaligned || (addr_reg < base_reg) ||
                   (|diff[PAGE_SHIFT-1:0]) || (quot >= ADDR_W'(eff_total));
        gidx      = {scan_word_reg, found_pos};
        grant_sum = 64'(base_reg) + (64'(gidx) << PAGE_SHIFT);
        bit_pos   = idx_reg[BIT_W-1:0];
        bit_val   = ram_rdata[bit_pos];
        taken     = (COUNT_W+1)'(used_reg) + (COUNT_W+1)'(rsvd_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_CLEAR;
            clr_addr_reg  <= '0;
            used_reg      <= '0;
            rsvd_reg      <= '0;
            base_reg      <= '0;
            total_reg     <= TOTAL_RESET;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            used_reg      <= used_next;
            rsvd_reg      <= rsvd_next;
            base_reg      <= base_next;
            total_reg     <= total_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        act_reg         <= act_next;
        addr_reg        <= addr_next;
        idx_reg         <= idx_next;
        scan_word_reg   <= scan_word_next;
        res_granted_reg <= res_granted_next;
        res_status_reg  <= res_status_next;
        m_granted_reg   <= m_granted_next;
        m_status_reg    <= m_status_next;
        m_free_reg      <= m_free_next;
        m_used_reg      <= m_used_next;
        m_rsvd_reg      <= m_rsvd_next;
    end

    always_comb begin
        state_next       = state_reg;
        act_next         = act_reg;
        addr_next        = addr_reg;
        idx_next         = idx_reg;
        scan_word_next   = scan_word_reg;
        clr_addr_next    = clr_addr_reg;
        used_next        = used_reg;
        rsvd_next        = rsvd_reg;
        base_next        = base_reg;
        total_next       = total_reg;
        res_granted_next = res_granted_reg;
        res_status_next  = res_status_reg;
        m_valid_next     = m_valid_reg;
        m_granted_next   = m_granted_reg;
        m_status_next    = m_status_reg;
        m_free_next      = m_free_reg;
        m_used_next      = m_used_reg;
        m_rsvd_next      = m_rsvd_reg;
        ram_we           = 1'b0;
        ram_waddr        = WORD_AW'(idx_reg >> BIT_W);
        ram_wdata        = ram_rdata;
        ram_raddr        = scan_word_reg + WORD_AW'(1);
        s_ready          = 1'b0;

        if (cfg_wr_en) begin
            unique case (cfg_reg_t'(cfg_index))
                REG_BASE_ADDRESS: base_next  = cfg_wdata;
                REG_TOTAL_PAGES:  total_next = cfg_wdata[COUNT_W-1:0];
            endcase
        end

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_CLEAR: begin
                ram_we        = 1'b1;
                ram_waddr     = clr_addr_reg;
                ram_wdata     = '0;
                clr_addr_next = clr_addr_reg + WORD_AW'(1);
                if (clr_addr_reg == LAST_WORD) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    act_next   = s_action;
                    addr_next  = s_page_address;
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                idx_next         = IDX_W'(quot);
                scan_word_next   = '0;
                res_granted_next = '0;
                res_status_next  = ST_OK;
                priority case (act_reg)
                    ACT_REQUEST: begin
                        ram_raddr = '0;
                        if (base_misaligned) begin
                            res_status_next = ST_BAD;
                            state_next      = S_OUT;
                        end else if (eff_total == '0) begin
                            res_status_next = ST_EXHAUSTED;
                            state_next      = S_OUT;
                        end else begin
                            state_next = S_SCAN;
                        end
                    end
                    ACT_LOCK, ACT_FREE, ACT_RESERVE, ACT_RELEASE: begin
                        ram_raddr = WORD_AW'(IDX_W'(quot) >> BIT_W);
                        if (addr_bad) begin
                            res_status_next = ST_BAD;
                            state_next      = S_OUT;
                        end else begin
                            state_next = S_MODIFY;
                        end
                    end
                    default: begin
                        state_next = S_OUT;
                    end
                endcase
            end
            S_SCAN: begin
                scan_word_next = scan_word_reg + WORD_AW'(1);
                if (found) begin
                    ram_we           = 1'b1;
                    ram_waddr        = scan_word_reg;
                    ram_wdata        = ram_rdata | (WORD_BITS'(1) << found_pos);
                    used_next        = (used_reg == COUNT_MAX) ? used_reg
                                                               : used_reg + COUNT_W'(1);
                    res_granted_next = grant_sum[ADDR_W-1:0] & GRANT_MASK;
                    state_next       = S_OUT;
                end else if (scan_word_reg == last_word) begin
                    res_status_next = ST_EXHAUSTED;
                    state_next      = S_OUT;
                end
            end
            S_MODIFY: begin
                state_next = S_OUT;
                if (act_reg == ACT_LOCK || act_reg == ACT_RESERVE) begin
                    if (bit_val) begin
                        res_status_next = ST_BUSY;
                    end else begin
                        ram_we    = 1'b1;
                        ram_wdata = ram_rdata | (WORD_BITS'(1) << bit_pos);
                        if (act_reg == ACT_LOCK) begin
                            used_next = (used_reg == COUNT_MAX) ? used_reg
                                                                : used_reg + COUNT_W'(1);
                        end else begin
                            rsvd_next = (rsvd_reg == COUNT_MAX) ? rsvd_reg
                                                                : rsvd_reg + COUNT_W'(1);
                        end
                    end
                end else begin
                    if (!bit_val) begin
                        res_status_next = ST_FREE;
                    end else begin
                        ram_we    = 1'b1;
                        ram_wdata = ram_rdata & ~(WORD_BITS'(1) << bit_pos);
                        if (act_reg == ACT_FREE) begin
                            used_next = (used_reg == '0) ? used_reg : used_reg - COUNT_W'(1);
                        end else begin
                            rsvd_next = (rsvd_reg == '0) ? rsvd_reg : rsvd_reg - COUNT_W'(1);
                        end
                    end
                end
            end
            S_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next   = 1'b1;
                    m_granted_next = res_granted_reg;
                    m_status_next  = res_status_reg;
                    m_free_next    = (taken >= (COUNT_W+1)'(eff_total)) ? '0
                                   : COUNT_W'((COUNT_W+1)'(eff_total) - taken);
                    m_used_next    = used_reg;
                    m_rsvd_next    = rsvd_reg;
                    state_next     = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign m_valid           = m_valid_reg;
    assign m_granted_address = m_granted_reg;
    assign m_status          = m_status_reg;
    assign m_free_pages      = m_free_reg;
    assign m_used_pages      = m_used_reg;
    assign m_reserved_pages  = m_rsvd_reg;

endmodule

FILE: rtl/core/bpfa_ram.sv
module bpfa_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                                   aclk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule
